// ===== src/sbt_pkg.sv =====
// sbt_pkg: token kinds, scan modes, keyword table and byte classes for the tokenizer
// used by every module of source_byte_tokenizer
`default_nettype none

package sbt_pkg;

    typedef logic [5:0] kind_t;

    localparam kind_t KIND_ILLEGAL = 6'd0;
    localparam kind_t KIND_EOF     = 6'd1;
    localparam kind_t KIND_IDENT   = 6'd2;
    localparam kind_t KIND_INT     = 6'd3;
    localparam kind_t KIND_ASSIGN  = 6'd4;
    localparam kind_t KIND_EQEQ    = 6'd5;
    localparam kind_t KIND_PLUS    = 6'd6;
    localparam kind_t KIND_MINUS   = 6'd7;
    localparam kind_t KIND_BANG    = 6'd8;
    localparam kind_t KIND_NEQ     = 6'd9;
    localparam kind_t KIND_SLASH   = 6'd10;
    localparam kind_t KIND_STAR    = 6'd11;
    localparam kind_t KIND_LT      = 6'd12;
    localparam kind_t KIND_GT      = 6'd13;
    localparam kind_t KIND_SEMI    = 6'd14;
    localparam kind_t KIND_COMMA   = 6'd15;
    localparam kind_t KIND_LBRACE  = 6'd16;
    localparam kind_t KIND_RBRACE  = 6'd17;
    localparam kind_t KIND_LPAREN  = 6'd18;
    localparam kind_t KIND_RPAREN  = 6'd19;
    localparam kind_t KIND_KW_FUNCTION = 6'd20;
    localparam kind_t KIND_KW_AUTO     = 6'd21;
    localparam kind_t KIND_KW_TRUE     = 6'd22;
    localparam kind_t KIND_KW_FALSE    = 6'd23;
    localparam kind_t KIND_KW_IF       = 6'd24;
    localparam kind_t KIND_KW_ELSE     = 6'd25;
    localparam kind_t KIND_KW_RETURN   = 6'd26;
    localparam kind_t KIND_KW_OUT      = 6'd27;
    localparam kind_t KIND_KW_FOR      = 6'd28;
    localparam kind_t KIND_KW_LOOP     = 6'd29;
    localparam kind_t KIND_KW_AND      = 6'd30;
    localparam kind_t KIND_KW_OR       = 6'd31;
    localparam kind_t KIND_KW_NOT      = 6'd32;
    localparam kind_t KIND_KW_CONTINUE = 6'd33;
    localparam kind_t KIND_KW_BREAK    = 6'd34;
    localparam kind_t KIND_KW_JUMPTO   = 6'd35;
    localparam kind_t KIND_KW_STRING   = 6'd36;
    localparam kind_t KIND_KW_CHAR     = 6'd37;

    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_NUL        = 8'h00;

    localparam int LEN_BITS     = 16;
    localparam int OFFSET_BITS  = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = 16'hFFFF;

    localparam int KW_MAX_CHARS = 8;
    localparam int KW_COUNT     = 19;

    // keyword text right-aligned, first character in the highest used byte
    localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        64'("function"), 64'("auto"), 64'("true"), 64'("false"), 64'("if"),
        64'("else"), 64'("return"), 64'("out"), 64'("for"), 64'("loop"),
        64'("and"), 64'("or"), 64'("not"), 64'("continue"), 64'("break"),
        64'("jumpto"), 64'("int"), 64'("string"), 64'("char")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd8, 4'd4, 4'd4, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3, 4'd3, 4'd4,
        4'd3, 4'd2, 4'd3, 4'd8, 4'd5, 4'd6, 4'd3, 4'd6, 4'd4
    };
    localparam kind_t KW_KIND [KW_COUNT] = '{
        KIND_KW_FUNCTION, KIND_KW_AUTO, KIND_KW_TRUE, KIND_KW_FALSE, KIND_KW_IF,
        KIND_KW_ELSE, KIND_KW_RETURN, KIND_KW_OUT, KIND_KW_FOR, KIND_KW_LOOP,
        KIND_KW_AND, KIND_KW_OR, KIND_KW_NOT, KIND_KW_CONTINUE, KIND_KW_BREAK,
        KIND_KW_JUMPTO, KIND_INT, KIND_KW_STRING, KIND_KW_CHAR
    };

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_EQ,
        MODE_BANG
    } scan_mode_t;

    typedef struct packed {
        kind_t                  kind;
        logic [OFFSET_BITS-1:0] start;
        logic [LEN_BITS-1:0]    length;
        logic                   last;
    } token_t;

    typedef struct packed {
        logic [1:0] cnt;
        token_t     e0;
        token_t     e1;
    } push_t;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // keyword k with character j in byte j, zeros beyond its length
    function automatic logic [8*KW_MAX_CHARS-1:0] kw_padded(input int k);
        logic [8*KW_MAX_CHARS-1:0] r;
        int l;
        r = '0;
        l = int'(KW_LEN[k]);
        for (int j = 0; j < KW_MAX_CHARS; j++) begin
            if (j < l) begin
                r[8*j +: 8] = KW_TEXT[k][8*(l-1-j) +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return b inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDERSCORE};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic kind_t single_kind(input logic [7:0] b);
        kind_t k;
        case (b)
            "+": k = KIND_PLUS;
            "-": k = KIND_MINUS;
            "/": k = KIND_SLASH;
            "*": k = KIND_STAR;
            "<": k = KIND_LT;
            ">": k = KIND_GT;
            ";": k = KIND_SEMI;
            ",": k = KIND_COMMA;
            "{": k = KIND_LBRACE;
            "}": k = KIND_RBRACE;
            "(": k = KIND_LPAREN;
            ")": k = KIND_RPAREN;
            default: k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== src/sbt_scanner.sv =====
// sbt_scanner: front part, accepts source bytes, tracks scan state and builds tokens
// depends on sbt_pkg; pushes up to two tokens per item into sbt_token_fifo
`default_nettype none

module sbt_scanner #(
    parameter int KEYWORD_CHARS = 8,
    parameter int POSITION_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tlast,
    input  wire logic          fifo_room,
    output sbt_pkg::push_t     push
);
    import sbt_pkg::*;

    localparam int BUF_BITS = 8 * KEYWORD_CHARS;

    scan_mode_t                    mode_reg, mode_next;
    logic [KEYWORD_CHARS-1:0][7:0] buf_reg, buf_next;
    logic [LEN_BITS-1:0]           len_reg, len_next;
    logic [POSITION_BITS-1:0]      start_reg, start_next;
    logic [POSITION_BITS-1:0]      pos_reg, pos_next;

    logic                          accept;
    logic                          eoi;
    logic                          fall;
    logic                          a_v, b_v;
    token_t                        tok_a, tok_b;
    kind_t                         word_kind;
    logic [POSITION_BITS-1:0]      pos_inc;
    logic [LEN_BITS-1:0]           len_inc;

    function automatic token_t make_tok(input kind_t k, input logic [POSITION_BITS-1:0] p,
                                        input logic [LEN_BITS-1:0] l);
        token_t t;
        logic [POSITION_BITS+OFFSET_BITS-1:0] ext;
        ext      = {{OFFSET_BITS{1'b0}}, p};
        t.kind   = k;
        t.start  = ext[OFFSET_BITS-1:0];
        t.length = l;
        t.last   = 1'b0;
        return t;
    endfunction

    assign s_tready = fifo_room;
    assign accept   = s_tvalid & fifo_room;
    assign eoi      = s_tlast | (s_tdata == CH_NUL);
    assign pos_inc  = pos_reg + POSITION_BITS'(1);
    assign len_inc  = (len_reg == LEN_MAX) ? len_reg : len_reg + LEN_BITS'(1);

    // keyword compare in parallel against the whole table
    always_comb begin
        word_kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (len_reg == LEN_BITS'(KW_LEN[k]) && buf_reg == BUF_BITS'(kw_padded(k))) begin
                word_kind = KW_KIND[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            buf_reg   <= '0;
            len_reg   <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            buf_reg   <= buf_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        buf_next   = buf_reg;
        len_next   = len_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        a_v        = 1'b0;
        b_v        = 1'b0;
        tok_a      = '0;
        tok_b      = '0;
        fall       = 1'b0;
        if (accept) begin
            case (mode_reg)
                MODE_WORD: begin
                    if (!eoi && (is_letter(s_tdata) || is_digit(s_tdata))) begin
                        for (int i = 0; i < KEYWORD_CHARS; i++) begin
                            if (len_reg == LEN_BITS'(i)) begin
                                buf_next[i] = s_tdata;
                            end
                        end
                        len_next = len_inc;
                        pos_next = pos_inc;
                    end else begin
                        a_v   = 1'b1;
                        tok_a = make_tok(word_kind, start_reg, len_reg);
                        fall  = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (!eoi && is_digit(s_tdata)) begin
                        len_next = len_inc;
                        pos_next = pos_inc;
                    end else begin
                        a_v   = 1'b1;
                        tok_a = make_tok(KIND_INT, start_reg, len_reg);
                        fall  = 1'b1;
                    end
                end
                MODE_EQ, MODE_BANG: begin
                    a_v = 1'b1;
                    if (!eoi && s_tdata == CH_EQ) begin
                        tok_a = make_tok((mode_reg == MODE_EQ) ? KIND_EQEQ : KIND_NEQ,
                                         start_reg, LEN_BITS'(2));
                        mode_next = MODE_IDLE;
                        pos_next  = pos_inc;
                    end else begin
                        tok_a = make_tok((mode_reg == MODE_EQ) ? KIND_ASSIGN : KIND_BANG,
                                         start_reg, LEN_BITS'(1));
                        fall  = 1'b1;
                    end
                end
                default: begin
                    fall = 1'b1;
                end
            endcase

            if (fall) begin
                mode_next = MODE_IDLE;
                if (eoi) begin
                    b_v      = 1'b1;
                    tok_b    = make_tok(KIND_EOF, pos_reg, '0);
                    pos_next = '0;
                end else begin
                    pos_next = pos_inc;
                    if (is_space(s_tdata)) begin
                        mode_next = MODE_IDLE;
                    end else if (s_tdata == CH_EQ) begin
                        mode_next  = MODE_EQ;
                        start_next = pos_reg;
                    end else if (s_tdata == CH_BANG) begin
                        mode_next  = MODE_BANG;
                        start_next = pos_reg;
                    end else if (single_kind(s_tdata) != KIND_ILLEGAL) begin
                        b_v   = 1'b1;
                        tok_b = make_tok(single_kind(s_tdata), pos_reg, LEN_BITS'(1));
                    end else if (is_letter(s_tdata) || is_digit(s_tdata)) begin
                        mode_next   = is_letter(s_tdata) ? MODE_WORD : MODE_NUM;
                        buf_next    = '0;
                        buf_next[0] = s_tdata;
                        len_next    = LEN_BITS'(1);
                        start_next  = pos_reg;
                    end else begin
                        b_v   = 1'b1;
                        tok_b = make_tok(KIND_ILLEGAL, pos_reg, LEN_BITS'(1));
                    end
                end
            end
        end

        push.cnt     = {1'b0, a_v} + {1'b0, b_v};
        push.e0      = a_v ? tok_a : tok_b;
        push.e1      = tok_b;
        push.e0.last = !(a_v && b_v);
        push.e1.last = 1'b1;
    end

endmodule

`default_nettype wire

// ===== src/sbt_token_fifo.sv =====
// sbt_token_fifo: short token queue between scanner and output stage
// depends on sbt_pkg; takes up to two tokens per cycle, gives one when popped
`default_nettype none

module sbt_token_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  sbt_pkg::push_t       push,
    output logic                 room,
    input  wire logic            pop,
    output logic                 rd_valid,
    output sbt_pkg::token_t      rd_data
);
    import sbt_pkg::*;

    token_t               mem_reg [FIFO_DEPTH];
    token_t               mem_next [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic [FIFO_AW-1:0]   wr_ptr_1;

    assign room     = count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign wr_ptr_1 = wr_ptr_reg + FIFO_AW'(1);

    always_comb begin
        for (int i = 0; i < FIFO_DEPTH; i++) begin
            mem_next[i] = mem_reg[i];
            if (push.cnt != 2'd0 && wr_ptr_reg == FIFO_AW'(i)) begin
                mem_next[i] = push.e0;
            end
            if (push.cnt == 2'd2 && wr_ptr_1 == FIFO_AW'(i)) begin
                mem_next[i] = push.e1;
            end
        end
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + (FIFO_AW+1)'(push.cnt) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < FIFO_DEPTH; i++) begin
            mem_reg[i] <= mem_next[i];
        end
    end

endmodule

`default_nettype wire

// ===== src/sbt_out_stage.sv =====
// sbt_out_stage: back part, registered result channel fed from the token queue
// depends on sbt_pkg
`default_nettype none

module sbt_out_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          rd_valid,
    input  sbt_pkg::token_t    rd_data,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,
    output logic [5:0]         m_tuser,
    output logic               m_tlast
);
    import sbt_pkg::*;

    logic   valid_reg, valid_next;
    token_t tok_reg, tok_next;

    assign pop = rd_valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        tok_next   = tok_reg;
        if (pop) begin
            valid_next = 1'b1;
            tok_next   = rd_data;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {tok_reg.length, tok_reg.start};
    assign m_tuser  = tok_reg.kind;
    assign m_tlast  = tok_reg.last;

endmodule

`default_nettype wire

// ===== src/source_byte_tokenizer.sv =====
// source_byte_tokenizer: top level, scanner front, token queue, registered output stage
// depends on sbt_pkg, sbt_scanner, sbt_token_fifo, sbt_out_stage
//
//   port group  dir  tdata                                   tuser         tlast
//   s_          in   byte_value [7:0]                        -             end_of_input
//   m_          out  start_offset [15:0], token_length [31:16] token_kind [5:0] last_of_run
//
// one source byte accepted per cycle while the token queue has room for two tokens
// each byte yields zero, one or two tokens; results leave at one per cycle while m_ is not stalled
// the four-entry queue plus output register let the input run on while m_ stalls, until the queue lacks room
// an accepted byte's tokens are registered in the queue, then in the output register, before reaching m_
// reset: synchronous aresetn clears scan state, byte position, queue and m_tvalid
`default_nettype none

module source_byte_tokenizer #(
    parameter int KEYWORD_CHARS = 8,
    parameter int POSITION_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // byte_value
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,   // start_offset, token_length
    output logic [5:0]         m_tuser,   // token_kind
    output logic               m_tlast
);
    import sbt_pkg::*;

    push_t  push;
    logic   room;
    logic   pop;
    logic   rd_valid;
    token_t rd_data;

    sbt_scanner #(
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .POSITION_BITS (POSITION_BITS)
    ) u_scanner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_room (room),
        .push      (push)
    );

    sbt_token_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .pop      (pop),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    sbt_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// tb: self-checking bench for source_byte_tokenizer, driving source bytes on s_ and
// checking every token on m_ against a cycle-free token predictor kept in the bench
// depends on sbt_pkg (token and kind types) and the source_byte_tokenizer rtl
module tb;
    import sbt_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // byte_value
    logic        s_tlast;   // end_of_input
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // start_offset, token_length
    logic [5:0]  m_tuser;   // token_kind
    logic        m_tlast;   // last_of_run

    source_byte_tokenizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // scanner state mirrored by the predictor
    scan_mode_t  scan_state = MODE_IDLE;
    logic [63:0] word_chars = '0;
    logic [15:0] word_len = '0;
    logic [15:0] tok_start = '0;
    logic [15:0] byte_pos = '0;

    token_t expected_tokens [$];
    int     mismatch_count = 0;
    int     text_items = 0;
    int     rx_hold = 0;
    bit     tx_idle = 1'b1;
    bit     rx_idle = 1'b1;

    string word_list [26] = '{
        "function", "auto", "true", "false", "if", "else", "return", "out", "for",
        "loop", "and", "or", "not", "continue", "break", "jumpto", "int", "string",
        "char", "functions", "continues", "conintue", "Int", "orr", "els", "i"
    };
    string op_chars = "+-/*<>;,{}()=!";
    string odd_chars = "@#$%&?.:[]|~`'^";
    string id_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic alpha_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
    endfunction

    function automatic logic num_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic kind_t op_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            "+": k = KIND_PLUS;
            "-": k = KIND_MINUS;
            "/": k = KIND_SLASH;
            "*": k = KIND_STAR;
            "<": k = KIND_LT;
            ">": k = KIND_GT;
            ";": k = KIND_SEMI;
            ",": k = KIND_COMMA;
            "{": k = KIND_LBRACE;
            "}": k = KIND_RBRACE;
            "(": k = KIND_LPAREN;
            ")": k = KIND_RPAREN;
            default: k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

    // word text is kept right-aligned, so a short word compares equal to its literal
    function automatic kind_t word_token_kind(input logic [63:0] w, input logic [15:0] n);
        kind_t k;
        k = KIND_IDENT;
        if (n <= 16'd8) begin
            case (w)
                "function": k = KIND_KW_FUNCTION;
                "auto":     k = KIND_KW_AUTO;
                "true":     k = KIND_KW_TRUE;
                "false":    k = KIND_KW_FALSE;
                "if":       k = KIND_KW_IF;
                "else":     k = KIND_KW_ELSE;
                "return":   k = KIND_KW_RETURN;
                "out":      k = KIND_KW_OUT;
                "for":      k = KIND_KW_FOR;
                "loop":     k = KIND_KW_LOOP;
                "and":      k = KIND_KW_AND;
                "or":       k = KIND_KW_OR;
                "not":      k = KIND_KW_NOT;
                "continue": k = KIND_KW_CONTINUE;
                "break":    k = KIND_KW_BREAK;
                "jumpto":   k = KIND_KW_JUMPTO;
                "int":      k = KIND_INT;
                "string":   k = KIND_KW_STRING;
                "char":     k = KIND_KW_CHAR;
                default:    k = KIND_IDENT;
            endcase
        end
        return k;
    endfunction

    function automatic token_t make_token(input kind_t k, input logic [15:0] s,
                                          input logic [15:0] l);
        token_t t;
        t.kind = k;
        t.start = s;
        t.length = l;
        t.last = 1'b0;
        return t;
    endfunction

    task automatic predict_tokens(input logic [7:0] b, input logic end_flag);
        logic eoi;
        logic consumed;
        int   base;
        eoi = end_flag || b == CH_NUL;
        consumed = 1'b0;
        base = expected_tokens.size();
        case (scan_state)
            MODE_WORD: begin
                if (!eoi && (alpha_char(b) || num_char(b))) begin
                    if (word_len < 16'd8) word_chars = {word_chars[55:0], b};
                    if (word_len != LEN_MAX) word_len = word_len + 16'd1;
                    consumed = 1'b1;
                end else begin
                    expected_tokens.push_back(make_token(word_token_kind(word_chars, word_len),
                                                         tok_start, word_len));
                end
            end
            MODE_NUM: begin
                if (!eoi && num_char(b)) begin
                    if (word_len != LEN_MAX) word_len = word_len + 16'd1;
                    consumed = 1'b1;
                end else begin
                    expected_tokens.push_back(make_token(KIND_INT, tok_start, word_len));
                end
            end
            MODE_EQ, MODE_BANG: begin
                if (!eoi && b == CH_EQ) begin
                    expected_tokens.push_back(make_token(
                        scan_state == MODE_EQ ? KIND_EQEQ : KIND_NEQ, tok_start, 16'd2));
                    scan_state = MODE_IDLE;
                    consumed = 1'b1;
                end else begin
                    expected_tokens.push_back(make_token(
                        scan_state == MODE_EQ ? KIND_ASSIGN : KIND_BANG, tok_start, 16'd1));
                end
            end
            default: ;
        endcase
        if (!consumed) scan_state = MODE_IDLE;
        if (!consumed && eoi) begin
            expected_tokens.push_back(make_token(KIND_EOF, byte_pos, 16'd0));
            byte_pos = '0;
        end else begin
            if (!consumed) begin
                if (blank_char(b)) begin
                end else if (b == CH_EQ || b == CH_BANG) begin
                    scan_state = (b == CH_EQ) ? MODE_EQ : MODE_BANG;
                    tok_start = byte_pos;
                end else if (op_kind(b) != KIND_ILLEGAL) begin
                    expected_tokens.push_back(make_token(op_kind(b), byte_pos, 16'd1));
                end else if (alpha_char(b) || num_char(b)) begin
                    scan_state = alpha_char(b) ? MODE_WORD : MODE_NUM;
                    word_chars = {56'd0, b};
                    word_len = 16'd1;
                    tok_start = byte_pos;
                end else begin
                    expected_tokens.push_back(make_token(KIND_ILLEGAL, byte_pos, 16'd1));
                end
            end
            byte_pos = byte_pos + 16'd1;
        end
        if (expected_tokens.size() > base) expected_tokens[$].last = 1'b1;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eoi);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eoi;
        do @(posedge aclk); while (!s_tready);
        predict_tokens(b, eoi);
        if (eoi || !blank_char(b)) text_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    endtask

    task automatic send_eof();
        if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(0, 255)), 1'b1);
        else push_byte(CH_NUL, 1'b0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_tokens.size() != 0);
    endtask

    // paired operators, held '=' and '!' broken by other bytes, every single op,
    // high bytes, and end of input by flag and by zero byte with tokens pending
    task automatic test_directed_cases();
        send_text("=a!=!1==+-*/<>;,{}()\t");
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(CH_EQ, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b1);
        push_byte("x", 1'b0);
        push_byte(CH_NUL, 1'b0);
    endtask

    // receiver holds off while single-char ops keep coming, so the queue fills
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_hold = 200;
        repeat (40) push_byte(op_chars[$urandom_range(0, 11)], 1'b0);
        wait_drained();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_text(input int count);
        int goal;
        int n;
        goal = text_items + count;
        while (text_items < goal) begin
            if ($urandom_range(0, 39) == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 15))
                0, 1, 2, 3: send_text(word_list[$urandom_range(0, 25)]);
                4, 5: begin
                    n = $urandom_range(1, 12);
                    push_byte(id_chars[$urandom_range(0, 52)], 1'b0);
                    repeat (n - 1) push_byte(id_chars[$urandom_range(0, 62)], 1'b0);
                end
                6: repeat ($urandom_range(1, 6)) push_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
                7, 8: push_byte(op_chars[$urandom_range(0, op_chars.len() - 1)], 1'b0);
                9: send_text(($urandom_range(0, 1) != 0) ? "==" : "!=");
                10: begin
                    if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(128, 255)), 1'b0);
                    else push_byte(odd_chars[$urandom_range(0, odd_chars.len() - 1)], 1'b0);
                end
                11: send_eof();
                12: push_byte(8'($urandom_range(1, 255)), 1'b0);
                default: begin
                    if ($urandom_range(0, 2) != 0) push_byte(" ", 1'b0);
                    else push_byte(8'($urandom_range(9, 13)), 1'b0);
                end
            endcase
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // word and digit runs well past the keyword width, the word opening with a keyword
    task automatic test_long_runs();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_text("continue");
        repeat (14) push_byte(id_chars[$urandom_range(0, 62)], 1'b0);
        push_byte(";", 1'b0);
        push_byte("7", 1'b0);
        repeat (19) push_byte("3", 1'b0);
        push_byte("+", 1'b0);
        send_eof();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin : receiver
        int wait_cycles;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            wait_cycles = rx_idle ? $urandom_range(0, 11) : 0;
            if (rx_hold > 0) begin
                wait_cycles = rx_hold;
                rx_hold = 0;
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : token_checker
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t: token mismatch: expected none, actual kind %0d start %0d length %0d",
                         $time, m_tuser, m_tdata[15:0], m_tdata[31:16]);
                mismatch_count++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", 16'(want.kind), 16'(m_tuser));
                check_field("start_offset", want.start, m_tdata[15:0]);
                check_field("token_length", want.length, m_tdata[31:16]);
                check_field("last_of_run", 16'(want.last), 16'(m_tlast));
            end
        end
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        s_tvalid <= 1'b0;
        s_tdata <= 8'h00;
        s_tlast <= 1'b0;
        aresetn <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        wait_drained();
        test_backpressure();
        test_random_text(330);
        wait_drained();
        test_long_runs();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== source_byte_tokenizer.f =====
src/sbt_pkg.sv
src/sbt_scanner.sv
src/sbt_token_fifo.sv
src/sbt_out_stage.sv
src/source_byte_tokenizer.sv
bench/tb.sv
